@@ design/mlqs_pkg.sv @@
// Shared types and constants of the multilevel queue scheduler.
package mlqs_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_FREE = 7'b0000010,
      ST_SCAN = 7'b0000100,
      ST_LAST = 7'b0001000,
      ST_UPD  = 7'b0010000,
      ST_INFO = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   // Request function codes.
   localparam logic FUNC_ADMIT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Response event codes.
   localparam logic [1:0] EV_ADMITTED = 2'd0;
   localparam logic [1:0] EV_REJECTED = 2'd1;
   localparam logic [1:0] EV_DONE     = 2'd2;

   // Register indexes.
   localparam logic REG_SLICE   = 1'b0;
   localparam logic REG_QUANTUM = 1'b1;

   localparam logic [7:0] SLICE_RESET   = 8'd20;
   localparam logic [7:0] QUANTUM_RESET = 8'd5;

   // Queue levels with special ordering rules.
   localparam logic [1:0] LEVEL_RR = 2'd3;

   // Control of the shared compare unit.
   typedef struct packed {
      logic clear;
      logic step;
      logic srtf;
   } scan_ctl_type;

endpackage

@@ design/mlqs_scan_unit.sv @@
// Shared compare unit that keeps the best candidate slot over a table scan.
module mlqs_scan_unit #(
   parameter int SLOT_BITS  = 4,
   parameter int BURST_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mlqs_pkg::scan_ctl_type ctl,
   input  logic                  cand_member,
   input  logic [SLOT_BITS-1:0]  cand_slot,
   input  logic [SLOT_BITS-1:0]  cand_pos,
   input  logic [BURST_BITS-1:0] cand_rem,
   output logic                  best_found,
   output logic [SLOT_BITS-1:0]  best_slot,
   output logic [SLOT_BITS-1:0]  best_pos,
   output logic [BURST_BITS-1:0] best_rem
);

   logic                  found_ff, found_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SLOT_BITS-1:0]  pos_ff, pos_in;
   logic [BURST_BITS-1:0] rem_ff, rem_in;
   logic                  better;

   // Shortest remaining first with earlier position on a tie; otherwise the head.
   always_comb begin
      if (ctl.srtf) begin
         better = !found_ff || (cand_rem < rem_ff) ||
                  ((cand_rem == rem_ff) && (cand_pos < pos_ff));
      end else begin
         better = (cand_pos == '0);
      end
   end

   always_comb begin
      found_in = found_ff;
      slot_in  = slot_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.step && cand_member && better) begin
         found_in = 1'b1;
         slot_in  = cand_slot;
         pos_in   = cand_pos;
         rem_in   = cand_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      slot_ff <= slot_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
   end

   assign best_found = found_ff;
   assign best_slot  = slot_ff;
   assign best_pos   = pos_ff;
   assign best_rem   = rem_ff;

   // A cleared unit stays empty into the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> !best_found) else $error("scan unit not cleared");

   // A kept best never grows in remaining time while shortest-first is scanned.
   a_srtf_monotone: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && ctl.srtf && found_ff) |=> (best_rem <= $past(rem_ff)))
      else $error("scan best grew");

   // A head pick always has position zero.
   a_head_pos: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && !ctl.srtf && cand_member && better) |=> (best_pos == '0))
      else $error("head pick not at position zero");

endmodule

@@ design/multilevel_queue_scheduler.sv @@
// Top level of the multilevel queue scheduler: sequencer, job table and stores.
// An admit is a free-slot search, one slot a cycle.
// A tick passes ST_SCAN, ST_LAST and ST_UPD, then ST_INFO and ST_FIN when a job completes: the job to
// serve is found by one compare unit that walks the table one slot per cycle
// through a single registered read port of the remaining-time memory. A tick with
// every queue empty does no scan. busy is high while an item is worked on. Each
// result appears on the rsp_ ports for one cycle with rsp_valid high, in the cycle after
// the item's work ends; it must be taken then, the block does not wait.
module multilevel_queue_scheduler #(
   parameter int TABLE_DEPTH = 16,
   parameter int BURST_BITS  = 12,
   parameter int TIME_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [BURST_BITS-1:0] req_burst_time,
   input  logic [1:0]            req_prio_level,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_event_kind,
   output logic [15:0]           rsp_job_id,
   output logic [15:0]           rsp_finish_time,
   output logic [15:0]           rsp_wait_time
);

   localparam int SLOT_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int INFO_BITS = 16 + TIME_BITS + BURST_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_DEPTH - 1);
   localparam logic [TIME_BITS-1:0] TIME_TOP  = '1;

   // Sequencer and request
   mlqs_pkg::state_type state_ff, state_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [BURST_BITS-1:0] req_burst_ff, req_burst_in;
   logic [1:0]            req_lvl_ff, req_lvl_in;

   // Configuration
   logic [7:0] slice_ticks_ff, slice_ticks_in;
   logic [7:0] rr_quantum_ff, rr_quantum_in;
   logic [7:0] slice_load, quantum_load;

   // Scheduling state
   logic [TIME_BITS-1:0] clock_now_ff, clock_now_in;
   logic [1:0]           serving_ff, serving_in;
   logic [7:0]           slice_left_ff, slice_left_in;
   logic [7:0]           quantum_left_ff, quantum_left_in;
   logic [15:0]          next_id_ff, next_id_in;
   logic [CNT_BITS-1:0]  cnt_ff [4];
   logic [CNT_BITS-1:0]  cnt_in [4];

   // Per-slot queue membership and position
   logic                 valid_ff [TABLE_DEPTH];
   logic                 valid_in [TABLE_DEPTH];
   logic [1:0]           lvl_ff [TABLE_DEPTH];
   logic [1:0]           lvl_in [TABLE_DEPTH];
   logic [SLOT_BITS-1:0] pos_ff [TABLE_DEPTH];
   logic [SLOT_BITS-1:0] pos_in [TABLE_DEPTH];

   // Stores
   logic [BURST_BITS-1:0] rem_mem [TABLE_DEPTH];
   logic [INFO_BITS-1:0]  info_mem [TABLE_DEPTH];
   logic [BURST_BITS-1:0] rem_rd_ff;
   logic [INFO_BITS-1:0]  info_rd_ff;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic                  rem_we, info_we;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [BURST_BITS-1:0] rem_wd;
   logic [INFO_BITS-1:0]  info_wd;

   // Scan pipeline
   logic                  pend_ff, pend_in;
   logic [SLOT_BITS-1:0]  pend_idx_ff, pend_idx_in;
   mlqs_pkg::scan_ctl_type scan_ctl;
   logic                  best_found;
   logic [SLOT_BITS-1:0]  best_slot, best_pos;
   logic [BURST_BITS-1:0] best_rem;
   logic                  cand_member;

   // Completion
   logic [TIME_BITS:0]    used_ff, used_in;
   logic [15:0]           done_id_ff, done_id_in;

   // Response
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_fin_ff, rsp_fin_in;
   logic [15:0] rsp_wait_ff, rsp_wait_in;

   // Helpers
   logic [1:0]            cur_lvl;
   logic                  accept;
   logic [BURST_BITS-1:0] burst_fix;
   logic                  q_found;
   logic [1:0]            q_pick;
   logic [BURST_BITS-1:0] rem_new;
   logic                  done;
   logic [CNT_BITS-1:0]   cnt_new;
   logic [7:0]            slice_new, quantum_new;
   logic                  slice_end, rot;
   logic [SLOT_BITS-1:0]  cnt_m1;
   logic [TIME_BITS:0]    wait_full;
   logic [TIME_BITS+15:0] fin_ext;
   logic [TIME_BITS+16:0] wait_ext;
   logic [CNT_BITS+1:0]   cnt_sum;
   logic [CNT_BITS+1:0]   valid_sum;

   assign accept       = start && !busy;
   assign busy         = (state_ff != mlqs_pkg::ST_IDLE);
   assign cur_lvl      = ~serving_ff;
   assign slice_load   = (slice_ticks_ff == 8'd0) ? 8'd1 : slice_ticks_ff;
   assign quantum_load = (rr_quantum_ff == 8'd0) ? 8'd1 : rr_quantum_ff;
   assign burst_fix    = (req_burst_time == '0) ? BURST_BITS'(1) : req_burst_time;
   assign cand_member  = valid_ff[pend_idx_ff] && (lvl_ff[pend_idx_ff] == cur_lvl);

   // First non-empty queue at or after the serving rank
   always_comb begin
      q_found = 1'b0;
      q_pick  = serving_ff;
      for (int r = 0; r < 4; r++) begin
         if (!q_found && (cnt_ff[~(serving_ff + 2'(r))] != '0)) begin
            q_found = 1'b1;
            q_pick  = serving_ff + 2'(r);
         end
      end
   end

   // Service step of the chosen job
   always_comb begin
      rem_new     = best_rem - BURST_BITS'(1);
      done        = (rem_new == '0);
      cnt_new     = done ? (cnt_ff[cur_lvl] - CNT_BITS'(1)) : cnt_ff[cur_lvl];
      slice_new   = slice_left_ff - 8'd1;
      quantum_new = done ? quantum_load :
                    ((quantum_left_ff != 8'd0) ? (quantum_left_ff - 8'd1) : quantum_left_ff);
      slice_end   = (slice_new == 8'd0) || (cnt_new == '0);
      rot         = (cur_lvl == mlqs_pkg::LEVEL_RR) && !done &&
                    (slice_end || (quantum_new == 8'd0));
      cnt_m1      = SLOT_BITS'(cnt_ff[cur_lvl] - CNT_BITS'(1));
   end

   // Wait time and saturation to the 16-bit result fields
   always_comb begin
      wait_full = ({1'b0, clock_now_ff} > used_ff) ? ({1'b0, clock_now_ff} - used_ff) : '0;
      fin_ext   = {16'd0, clock_now_ff};
      wait_ext  = {16'd0, wait_full};
   end

   // Store read and write port control
   always_comb begin
      rd_addr = state_ff[$clog2(mlqs_pkg::ST_UPD)] ? best_slot : idx_ff;
      rem_we  = 1'b0;
      info_we = 1'b0;
      wr_addr = idx_ff;
      rem_wd  = req_burst_ff;
      info_wd = {next_id_ff, clock_now_ff, req_burst_ff};
      if (state_ff == mlqs_pkg::ST_FREE && !valid_ff[idx_ff]) begin
         rem_we  = 1'b1;
         info_we = 1'b1;
      end else if (state_ff == mlqs_pkg::ST_UPD) begin
         rem_we  = 1'b1;
         wr_addr = best_slot;
         rem_wd  = rem_new;
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      req_burst_in    = req_burst_ff;
      req_lvl_in      = req_lvl_ff;
      clock_now_in    = clock_now_ff;
      serving_in      = serving_ff;
      slice_left_in   = slice_left_ff;
      quantum_left_in = quantum_left_ff;
      next_id_in      = next_id_ff;
      cnt_in          = cnt_ff;
      valid_in        = valid_ff;
      lvl_in          = lvl_ff;
      pos_in          = pos_ff;
      pend_in         = 1'b0;
      pend_idx_in     = idx_ff;
      used_in         = used_ff;
      done_id_in      = done_id_ff;
      scan_ctl.clear  = 1'b0;
      scan_ctl.step   = pend_ff;
      scan_ctl.srtf   = (cur_lvl == 2'd1) || (cur_lvl == 2'd2);
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_fin_in      = rsp_fin_ff;
      rsp_wait_in     = rsp_wait_ff;

      case (state_ff)
         mlqs_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in       = '0;
               req_burst_in = burst_fix;
               req_lvl_in   = req_prio_level;
               if (req_func == mlqs_pkg::FUNC_ADMIT) begin
                  state_in = mlqs_pkg::ST_FREE;
               end else begin
                  clock_now_in   = (clock_now_ff != TIME_TOP) ?
                                   (clock_now_ff + TIME_BITS'(1)) : clock_now_ff;
                  scan_ctl.clear = 1'b1;
                  if (slice_left_ff != 8'd0) begin
                     state_in = mlqs_pkg::ST_SCAN;
                  end else if (q_found) begin
                     serving_in      = q_pick;
                     slice_left_in   = slice_load;
                     quantum_left_in = quantum_load;
                     state_in        = mlqs_pkg::ST_SCAN;
                  end
               end
            end
         end
         mlqs_pkg::ST_FREE: begin
            if (!valid_ff[idx_ff]) begin
               valid_in[idx_ff]    = 1'b1;
               lvl_in[idx_ff]      = req_lvl_ff;
               pos_in[idx_ff]      = SLOT_BITS'(cnt_ff[req_lvl_ff]);
               cnt_in[req_lvl_ff]  = cnt_ff[req_lvl_ff] + CNT_BITS'(1);
               next_id_in          = next_id_ff + 16'd1;
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = mlqs_pkg::EV_ADMITTED;
               rsp_id_in           = next_id_ff;
               rsp_fin_in          = '0;
               rsp_wait_in         = '0;
               state_in            = mlqs_pkg::ST_IDLE;
            end else if (idx_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mlqs_pkg::EV_REJECTED;
               rsp_id_in    = '0;
               rsp_fin_in   = '0;
               rsp_wait_in  = '0;
               state_in     = mlqs_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         mlqs_pkg::ST_SCAN: begin
            pend_in = 1'b1;
            if (idx_ff == LAST_SLOT) begin
               state_in = mlqs_pkg::ST_LAST;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         mlqs_pkg::ST_LAST: begin
            state_in = mlqs_pkg::ST_UPD;
         end
         mlqs_pkg::ST_UPD: begin
            // Per-slot queue position update on completion or rotation
            for (int s = 0; s < TABLE_DEPTH; s++) begin
               if (valid_ff[s] && (lvl_ff[s] == cur_lvl)) begin
                  if (done && (pos_ff[s] > best_pos)) begin
                     pos_in[s] = pos_ff[s] - SLOT_BITS'(1);
                  end else if (rot) begin
                     pos_in[s] = (pos_ff[s] == '0) ? cnt_m1 : (pos_ff[s] - SLOT_BITS'(1));
                  end
               end
            end
            if (done) begin
               valid_in[best_slot] = 1'b0;
            end
            cnt_in[cur_lvl] = cnt_new;
            if (slice_end) begin
               slice_left_in   = 8'd0;
               quantum_left_in = quantum_new;
               serving_in      = serving_ff + 2'd1;
            end else begin
               slice_left_in   = slice_new;
               quantum_left_in = rot ? quantum_load : quantum_new;
            end
            state_in = done ? mlqs_pkg::ST_INFO : mlqs_pkg::ST_IDLE;
         end
         mlqs_pkg::ST_INFO: begin
            used_in    = (TIME_BITS+1)'(info_rd_ff[BURST_BITS +: TIME_BITS]) +
                         (TIME_BITS+1)'(info_rd_ff[BURST_BITS-1:0]);
            done_id_in = info_rd_ff[INFO_BITS-1 -: 16];
            state_in   = mlqs_pkg::ST_FIN;
         end
         mlqs_pkg::ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mlqs_pkg::EV_DONE;
            rsp_id_in    = done_id_ff;
            rsp_fin_in   = (|fin_ext[TIME_BITS+15:16]) ? 16'hFFFF : fin_ext[15:0];
            rsp_wait_in  = (|wait_ext[TIME_BITS+16:16]) ? 16'hFFFF : wait_ext[15:0];
            state_in     = mlqs_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlqs_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      slice_ticks_in = slice_ticks_ff;
      rr_quantum_in  = rr_quantum_ff;
      if (csr_we) begin
         case (csr_index)
            mlqs_pkg::REG_SLICE:   slice_ticks_in = csr_wdata;
            mlqs_pkg::REG_QUANTUM: rr_quantum_in  = csr_wdata;
            default:               slice_ticks_in = slice_ticks_ff;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mlqs_pkg::ST_IDLE;
         slice_ticks_ff  <= mlqs_pkg::SLICE_RESET;
         rr_quantum_ff   <= mlqs_pkg::QUANTUM_RESET;
         clock_now_ff    <= '0;
         serving_ff      <= 2'd0;
         slice_left_ff   <= 8'd0;
         quantum_left_ff <= 8'd0;
         next_id_ff      <= 16'd1;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int q = 0; q < 4; q++) begin
            cnt_ff[q] <= '0;
         end
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         state_ff        <= state_in;
         slice_ticks_ff  <= slice_ticks_in;
         rr_quantum_ff   <= rr_quantum_in;
         clock_now_ff    <= clock_now_in;
         serving_ff      <= serving_in;
         slice_left_ff   <= slice_left_in;
         quantum_left_ff <= quantum_left_in;
         next_id_ff      <= next_id_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
         cnt_ff          <= cnt_in;
         valid_ff        <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      req_burst_ff <= req_burst_in;
      req_lvl_ff   <= req_lvl_in;
      lvl_ff       <= lvl_in;
      pos_ff       <= pos_in;
      pend_idx_ff  <= pend_idx_in;
      used_ff      <= used_in;
      done_id_ff   <= done_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_wait_ff  <= rsp_wait_in;
   end

   // Remaining-time and job-info stores, registered read
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[wr_addr] <= rem_wd;
      end
      if (info_we) begin
         info_mem[wr_addr] <= info_wd;
      end
      rem_rd_ff  <= rem_mem[rd_addr];
      info_rd_ff <= info_mem[rd_addr];
   end

   mlqs_scan_unit #(
      .SLOT_BITS  (SLOT_BITS),
      .BURST_BITS (BURST_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .cand_member (cand_member),
      .cand_slot   (pend_idx_ff),
      .cand_pos    (pos_ff[pend_idx_ff]),
      .cand_rem    (rem_rd_ff),
      .best_found  (best_found),
      .best_slot   (best_slot),
      .best_pos    (best_pos),
      .best_rem    (best_rem)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_job_id      = rsp_id_ff;
   assign rsp_finish_time = rsp_fin_ff;
   assign rsp_wait_time   = rsp_wait_ff;

   // Queue counts add up to the number of occupied slots
   always_comb begin
      cnt_sum = (CNT_BITS+2)'(cnt_ff[0]) + (CNT_BITS+2)'(cnt_ff[1]) +
                (CNT_BITS+2)'(cnt_ff[2]) + (CNT_BITS+2)'(cnt_ff[3]);
      valid_sum = '0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         valid_sum = valid_sum + (CNT_BITS+2)'(valid_ff[s]);
      end
   end

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (cnt_sum == valid_sum)) else $error("queue counts off");

   a_update_has_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlqs_pkg::ST_UPD) |-> best_found) else $error("no job to serve");

   a_done_from_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == mlqs_pkg::EV_DONE)) |->
      $past(state_ff == mlqs_pkg::ST_FIN)) else $error("completion out of sequence");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == mlqs_pkg::FUNC_ADMIT)) |=> busy)
      else $error("admit did not start");

endmodule
